// File: design/lsba_pkg.sv
// Shared types and constants of the LIFO scratch block allocator.
// Used by the channel interfaces and the top level; depends on nothing.
package lsba_pkg;

  localparam int MAX_BLOCKS  = 64;
  localparam int IDX_W       = $clog2(MAX_BLOCKS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ALIGN_BYTES = 16;
  localparam int ALIGN_LG2   = $clog2(ALIGN_BYTES);
  localparam int DATA_W      = 32;

  localparam logic [DATA_W-1:0] SAFETY_MARGIN = DATA_W'(64);
  localparam logic [DATA_W-1:0] CAP_RESET     = DATA_W'(1048576);
  localparam logic [DATA_W-1:0] CAP_MAX       =
    {{(DATA_W-ALIGN_LG2){1'b1}}, {ALIGN_LG2{1'b0}}};

  typedef enum logic [2:0] {
    KIND_OPEN  = 3'd0,
    KIND_END   = 3'd1,
    KIND_FREE  = 3'd2,
    KIND_TEST  = 3'd3,
    KIND_QUERY = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_ALREADY_OPEN = 3'd1,
    ST_TOO_MANY     = 3'd2,
    ST_TOO_SMALL    = 3'd3,
    ST_NOT_OPEN     = 3'd4,
    ST_FREE_OPEN    = 3'd5,
    ST_OUT_OF_ORDER = 3'd6
  } status_t;

endpackage

// File: design/lsba_if.sv
// Request and response channel interfaces of the scratch block allocator.
// Depends on lsba_pkg for field widths.
interface lsba_req_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  kind;
  logic [lsba_pkg::IDX_W-1:0]  block_index;
  logic [lsba_pkg::DATA_W-1:0] size_bytes;

  modport source (output valid, kind, block_index, size_bytes, input ready);
  modport sink   (input valid, kind, block_index, size_bytes, output ready);
endinterface

interface lsba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [lsba_pkg::IDX_W-1:0]  block_number;
  logic [lsba_pkg::DATA_W-1:0] block_offset;
  logic [lsba_pkg::DATA_W-1:0] block_size;
  logic [lsba_pkg::DATA_W-1:0] available;
  logic [lsba_pkg::DATA_W-1:0] high_water;

  modport source (output valid, status, block_number, block_offset, block_size,
                  available, high_water, input ready);
  modport sink   (input valid, status, block_number, block_offset, block_size,
                  available, high_water, output ready);
endinterface

// File: design/lifo_scratch_block_allocator.sv
// Stack-ordered scratch block allocator over a byte region.
// Uses lsba_pkg and the lsba_req_if / lsba_rsp_if channel interfaces.
//
// Usage:
//   in_req carries one request: open, end, free, test fit or query size.
//   out_rsp returns exactly one response per request, in request order.
//   cfg_we / cfg_wdata write the region capacity; write it only while idle.
// Path: an accepted request passes the input register, then the response register.
// Throughput: one request per cycle while out_rsp.ready is high. The
//   size table is read at the request's block index as the request is
//   registered, with a bypass from the write of the request ahead of it,
//   so no bubble is needed.
// Reset: block count, open flag, claimed total and high-water mark clear,
//   capacity returns to 1 MiB. The size table is not cleared; only entries
//   below the block count are ever used, and each was written by an open.
// Stall: while out_rsp.ready is low the response holds, one more request
//   may enter the input register, then in_req.ready drops until the
//   response is taken.
module lifo_scratch_block_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lsba_pkg::DATA_W-1:0] cfg_wdata,
  lsba_req_if.sink                    in_req,
  lsba_rsp_if.source                  out_rsp
);

  localparam int DW = lsba_pkg::DATA_W;
  localparam int IW = lsba_pkg::IDX_W;
  localparam int CW = lsba_pkg::CNT_W;
  localparam int AL = lsba_pkg::ALIGN_LG2;

  // Allocator state
  logic [DW-1:0] cap_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          open_r, open_nxt;
  logic [DW-1:0] claimed_r, claimed_nxt;
  logic [DW-1:0] peak_r, peak_nxt;

  // Input register
  logic                 s1_valid_r;
  lsba_pkg::kind_t      s1_kind_r;
  logic [IW-1:0]        s1_idx_r;
  logic [DW-1:0]        s1_size_r;
  logic [DW-1:0]        rd_r;

  // Response register
  logic                 out_valid_r;
  lsba_pkg::status_t    status_r, status_nxt;
  logic [IW-1:0]        bnum_r, bnum_nxt;
  logic [DW-1:0]        boff_r, boff_nxt;
  logic [DW-1:0]        bsize_r, bsize_nxt;
  logic [DW-1:0]        avail_r, avail_nxt;
  logic [DW-1:0]        hw_r;

  // Size table
  logic [DW-1:0] size_mem [lsba_pkg::MAX_BLOCKS];
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  logic          adv;
  logic          in_acc;
  logic [DW-1:0] cap_nxt;

  // Datapath terms
  logic [DW:0]   rs;
  logic [DW+1:0] nc;
  logic [DW+1:0] np;
  logic [DW:0]   test_sum;
  logic [DW:0]   claim_margin;
  logic          is_top;

  // Handshake: advance the input register when the response slot frees
  assign adv          = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !s1_valid_r || adv;
  assign in_acc       = in_req.valid && in_req.ready;

  // Round the written capacity up to the alignment, saturating
  always_comb begin
    if (cfg_wdata[AL-1:0] == '0) begin
      cap_nxt = cfg_wdata;
    end else if (cfg_wdata[DW-1:AL] == '1) begin
      cap_nxt = lsba_pkg::CAP_MAX;
    end else begin
      cap_nxt = {cfg_wdata[DW-1:AL] + (DW-AL)'(1), {AL{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lsba_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cap_nxt;
    end
  end

  // Arithmetic for end and test, and the top-of-stack check for end and free
  assign rs = {({1'b0, s1_size_r[DW-1:AL]} + (DW-AL+1)'(|s1_size_r[AL-1:0])),
               {AL{1'b0}}};
  assign nc       = {2'b00, claimed_r} + {1'b0, rs};
  assign np       = ({2'b00, peak_r} > nc) ? {2'b00, peak_r} : nc;
  assign test_sum = {1'b0, claimed_r} + {1'b0, s1_size_r};
  assign is_top   = (count_r != '0) && ({1'b0, s1_idx_r} == (count_r - CW'(1)));

  // Decode the request and compute the next state
  always_comb begin
    count_nxt   = count_r;
    open_nxt    = open_r;
    claimed_nxt = claimed_r;
    peak_nxt    = peak_r;
    status_nxt  = lsba_pkg::ST_OK;
    bnum_nxt    = '0;
    boff_nxt    = '0;
    bsize_nxt   = '0;
    wr_en       = 1'b0;
    wr_addr     = s1_idx_r;
    wr_data     = '0;
    case (s1_kind_r)
      lsba_pkg::KIND_OPEN: begin
        if (open_r) begin
          status_nxt = lsba_pkg::ST_ALREADY_OPEN;
        end else if (count_r >= CW'(lsba_pkg::MAX_BLOCKS - 1)) begin
          status_nxt = lsba_pkg::ST_TOO_MANY;
        end else begin
          bnum_nxt  = count_r[IW-1:0];
          boff_nxt  = claimed_r;
          bsize_nxt = (cap_r > claimed_r) ? cap_r - claimed_r : '0;
          wr_en     = 1'b1;
          wr_addr   = count_r[IW-1:0];
          wr_data   = bsize_nxt;
          count_nxt = count_r + CW'(1);
          open_nxt  = 1'b1;
        end
      end
      lsba_pkg::KIND_END: begin
        if (!open_r || !is_top) begin
          status_nxt = lsba_pkg::ST_NOT_OPEN;
        end else if (np > {2'b00, cap_r}) begin
          status_nxt = lsba_pkg::ST_TOO_SMALL;
        end else begin
          claimed_nxt = nc[DW-1:0];
          peak_nxt    = np[DW-1:0];
          wr_en       = 1'b1;
          wr_data     = rs[DW-1:0];
          open_nxt    = 1'b0;
        end
      end
      lsba_pkg::KIND_FREE: begin
        if (open_r) begin
          status_nxt = lsba_pkg::ST_FREE_OPEN;
        end else if (!is_top) begin
          status_nxt = lsba_pkg::ST_OUT_OF_ORDER;
        end else begin
          count_nxt   = count_r - CW'(1);
          claimed_nxt = (claimed_r > rd_r) ? claimed_r - rd_r : '0;
        end
      end
      lsba_pkg::KIND_TEST: begin
        if (test_sum > {1'b0, cap_r}) begin
          status_nxt = lsba_pkg::ST_TOO_SMALL;
        end
      end
      lsba_pkg::KIND_QUERY: begin
        if ({1'b0, s1_idx_r} < count_r) begin
          bsize_nxt = rd_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Available space after the step, less the safety margin, floored at zero
  assign claim_margin = {1'b0, claimed_nxt} + {1'b0, lsba_pkg::SAFETY_MARGIN};
  assign avail_nxt    = ({1'b0, cap_r} > claim_margin) ?
                        DW'({1'b0, cap_r} - claim_margin) : '0;

  // Write the size table as a request retires
  always_ff @(posedge clk) begin
    if (adv && wr_en) begin
      size_mem[wr_addr] <= wr_data;
    end
  end

  // Read at the incoming index, bypassing the write of the same edge
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (adv && wr_en && (wr_addr == in_req.block_index)) begin
        rd_r <= wr_data;
      end else begin
        rd_r <= size_mem[in_req.block_index];
      end
    end
  end

  // Hold or load the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= lsba_pkg::kind_t'(in_req.kind);
      s1_idx_r  <= in_req.block_index;
      s1_size_r <= in_req.size_bytes;
    end
  end

  // Update allocator state as a request retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      open_r    <= 1'b0;
      claimed_r <= '0;
      peak_r    <= '0;
    end else if (adv) begin
      count_r   <= count_nxt;
      open_r    <= open_nxt;
      claimed_r <= claimed_nxt;
      peak_r    <= peak_nxt;
    end
  end

  // Response register: drop valid when taken, load on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= status_nxt;
      bnum_r   <= bnum_nxt;
      boff_r   <= boff_nxt;
      bsize_r  <= bsize_nxt;
      avail_r  <= avail_nxt;
      hw_r     <= peak_nxt;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = status_r;
  assign out_rsp.block_number = bnum_r;
  assign out_rsp.block_offset = boff_r;
  assign out_rsp.block_size   = bsize_r;
  assign out_rsp.available    = avail_r;
  assign out_rsp.high_water   = hw_r;

`ifndef SYNTHESIS
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(lsba_pkg::MAX_BLOCKS - 1))
    else $error("block count beyond table depth");

  a_claim_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
    claimed_r <= peak_r)
    else $error("claimed total above high-water mark");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(count_r) && $stable(claimed_r) && $stable(open_r)))
    else $error("allocator state changed without a retiring request");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_valid_r || !out_valid_r) |-> in_req.ready)
    else $error("request refused with a free slot");
`endif

endmodule
